// ----- rtl/core/nmea_sp_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence parser package
// Shared limits, character codes, phase and status types and the state and
// result records passed between the decode logic and the top level.
// ----------------------------------------------------------------------------
package nmea_sp_pkg;

    // Sentence limits.
    localparam int MAX_LEN         = 128;
    localparam int MAX_FIELDS      = 32;
    localparam int MAX_FIELD_CHARS = 16;

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int FC_W  = $clog2(MAX_FIELDS);
    localparam int CC_W  = $clog2(MAX_FIELD_CHARS + 1);

    // Widths of the reported position fields.
    localparam int FIELD_IDX_W = 5;
    localparam int CHAR_IDX_W  = 4;

    // Framing characters.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_SUM  = 2'd2,
        PH_TAIL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_RESTART  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_BAD_HEX  = 3'd4
    } status_t;

    typedef struct packed {
        phase_t           phase;
        logic [LEN_W-1:0] sentence_length;
        logic [FC_W-1:0]  field_count;
        logic [CC_W-1:0]  field_char_count;
        logic [7:0]       running_xor;
        logic [7:0]       received_sum;
        logic [1:0]       hex_digit_count;
        logic             digit_error;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]             byte_out;
        logic [FIELD_IDX_W-1:0] field_index;
        logic [CHAR_IDX_W-1:0]  char_index;
        logic                   is_field_char;
        logic                   field_end;
        logic                   sentence_end;
        logic                   checksum_present;
        logic                   checksum_ok;
        status_t                status;
    } parse_result_t;

    // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/nmea_sp_decode.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence parser byte decode
// Combinational next state and result for one received byte.
// ----------------------------------------------------------------------------
module nmea_sp_decode
    import nmea_sp_pkg::*;
(
    input  logic [7:0]    rx_byte,
    input  parse_state_t  cur,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [4:0] hv;

    assign hv = hex_value(rx_byte);

    always_comb
    begin
        nxt          = cur;
        res          = '0;
        res.byte_out = rx_byte;
        res.status   = ST_OK;

        if (rx_byte == CH_DOLLAR)
        begin
            res.status = (cur.phase == PH_IDLE) ? ST_OK : ST_RESTART;
            nxt        = '0;
            nxt.phase  = PH_DATA;
        end
        else if (cur.phase == PH_IDLE)
        begin
            res.status = ST_IGNORED;
        end
        else
        begin
            res.field_index = FIELD_IDX_W'(cur.field_count);
            if (cur.sentence_length >= LEN_W'(MAX_LEN - 1))
            begin
                res.status = ST_OVERFLOW;
                nxt.phase  = PH_IDLE;
            end
            else
            begin
                nxt.sentence_length = cur.sentence_length + 1'b1;
                if (rx_byte == CH_LF)
                begin
                    res.sentence_end     = 1'b1;
                    res.checksum_present = (cur.hex_digit_count == 2'd2) && !cur.digit_error;
                    res.checksum_ok      = res.checksum_present &&
                                           (cur.received_sum == cur.running_xor);
                    nxt.phase            = PH_IDLE;
                end
                else
                begin
                    unique case (cur.phase)
                        PH_DATA:
                        begin
                            if (rx_byte == CH_COMMA)
                            begin
                                if ((FC_W+1)'(cur.field_count) + 1'b1 >= (FC_W+1)'(MAX_FIELDS))
                                begin
                                    res.status = ST_OVERFLOW;
                                    nxt.phase  = PH_IDLE;
                                end
                                else
                                begin
                                    res.field_end        = 1'b1;
                                    nxt.running_xor      = cur.running_xor ^ rx_byte;
                                    nxt.field_count      = cur.field_count + 1'b1;
                                    nxt.field_char_count = '0;
                                end
                            end
                            else if (rx_byte == CH_STAR)
                            begin
                                res.field_end = 1'b1;
                                nxt.phase     = PH_SUM;
                            end
                            else if (cur.field_char_count >= CC_W'(MAX_FIELD_CHARS))
                            begin
                                res.status = ST_OVERFLOW;
                                nxt.phase  = PH_IDLE;
                            end
                            else
                            begin
                                res.is_field_char    = 1'b1;
                                res.char_index       = CHAR_IDX_W'(cur.field_char_count);
                                nxt.field_char_count = cur.field_char_count + 1'b1;
                                nxt.running_xor      = cur.running_xor ^ rx_byte;
                            end
                        end
                        PH_SUM:
                        begin
                            if (!hv[4])
                            begin
                                nxt.digit_error = 1'b1;
                                res.status      = ST_BAD_HEX;
                            end
                            // An invalid digit shifts in as zero.
                            nxt.received_sum    = {cur.received_sum[3:0], hv[3:0]};
                            nxt.hex_digit_count = cur.hex_digit_count + 1'b1;
                            if (cur.hex_digit_count >= 2'd1)
                            begin
                                nxt.phase = PH_TAIL;
                            end
                        end
                        default:
                        begin
                            // Tail bytes such as a carriage return carry no meaning.
                        end
                    endcase
                end
            end
        end
    end

endmodule

// ----- rtl/core/nmea_sentence_parser_core.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence parser core
// Frames NMEA 0183 sentences one received byte at a time and reports, for
// every byte, its field and character position, field and sentence ends and
// the checksum verdict.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                      Framing
//  s_axis    in   tdata[7:0] rx_byte                           -
//  m_axis    out  tdata[20:0] byte/position/flags, tuser status tlast = sentence end
//
// One transfer in gives exactly one transfer out, through the input register and
// then the result register. A new byte can be taken on every cycle while the
// output side is not stalled; the throughput is one byte per clock, set by the
// combinational decode between the input register and the result register.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the idle phase, outside any sentence.
// When m_axis_tready is low the result register holds; the input register
// still takes one more byte, and s_axis_tready falls only once both are full.
// ----------------------------------------------------------------------------
module nmea_sentence_parser_core
    import nmea_sp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [12:8] field_index,
                                        // [16:13] char_index, [17] is_field_char,
                                        // [18] field_end, [19] checksum_present,
                                        // [20] checksum_ok, [23:21] zero
    output logic        m_axis_tlast,   // sentence_end
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    // Input register stage.
    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_byte_reg;

    // Parser state, updated as a byte moves into the result register.
    parse_state_t  state_reg;
    parse_state_t  state_next;

    // Result register stage.
    logic          out_valid_reg;
    logic          out_valid_next;
    parse_result_t res_reg;
    parse_result_t res_next;

    logic          out_free;
    logic          advance;
    logic          in_accept;

    // The result register can take a new entry when empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    nmea_sp_decode u_decode
    (
        .rx_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            res_reg.checksum_ok,
                            res_reg.checksum_present,
                            res_reg.field_end,
                            res_reg.is_field_char,
                            res_reg.char_index,
                            res_reg.field_index,
                            res_reg.byte_out};
    assign m_axis_tlast  = res_reg.sentence_end;
    assign m_axis_tuser  = res_reg.status;

    // A sentence end is only ever reported with an ok status.
    a_end_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ST_OK))
        else $error("sentence end reported with a non-ok status");

    // A matching checksum implies a checksum was present at a sentence end.
    a_ok_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[20]) |-> (m_axis_tdata[19] && m_axis_tlast))
        else $error("checksum ok without checksum present at sentence end");

    // A byte is never both a stored character and a field delimiter.
    a_char_or_delim: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[18]))
        else $error("byte flagged as field character and field end");

    // An overflow or a sentence end drops the parser back to idle.
    a_drop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_next.status == ST_OVERFLOW || res_next.sentence_end))
        |=> (state_reg.phase == PH_IDLE))
        else $error("parser not idle after overflow or sentence end");

    // A new result is only loaded when the previous one has gone.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule
